[hdl/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;

    localparam logic [CHAR_W-1:0] CODE_NUL       = 8'd0;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'd7;

    typedef struct packed {
        logic                 write_valid;
        logic [OUT_ROW_W-1:0] write_row;
        logic [OUT_COL_W-1:0] write_col;
        logic [CHAR_W-1:0]    write_glyph;
        logic [ATTR_W-1:0]    write_attr;
        logic                 scroll_request;
        logic [OUT_ROW_W-1:0] cursor_row_out;
        logic [OUT_COL_W-1:0] cursor_col_out;
    } result_t;

endpackage

[hdl/tcce_if.sv]
// ----------------------------------------------------------------------------
// tcce_char_if / tcce_result_if
// Valid/ready channels for character codes and cursor results.
// ----------------------------------------------------------------------------
interface tcce_char_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tcce_result_if;
    import tcce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 write_valid;
    logic [OUT_ROW_W-1:0] write_row;
    logic [OUT_COL_W-1:0] write_col;
    logic [CHAR_W-1:0]    write_glyph;
    logic [ATTR_W-1:0]    write_attr;
    logic                 scroll_request;
    logic [OUT_ROW_W-1:0] cursor_row_out;
    logic [OUT_COL_W-1:0] cursor_col_out;

    modport source (
        output valid, output write_valid, output write_row, output write_col,
        output write_glyph, output write_attr, output scroll_request,
        output cursor_row_out, output cursor_col_out, input ready
    );
    modport sink (
        input valid, input write_valid, input write_row, input write_col,
        input write_glyph, input write_attr, input scroll_request,
        input cursor_row_out, input cursor_col_out, output ready
    );
endinterface

[hdl/tcce_cursor_step.sv]
// ----------------------------------------------------------------------------
// tcce_cursor_step
// Next cursor position and cell write for one character code.
// ----------------------------------------------------------------------------
module tcce_cursor_step (
    input  logic [tcce_pkg::COL_W-1:0]  cursor_col,
    input  logic [tcce_pkg::ROW_W-1:0]  cursor_row,
    input  logic [tcce_pkg::CHAR_W-1:0] char_code,
    input  logic [tcce_pkg::ATTR_W-1:0] text_color,
    output logic [tcce_pkg::COL_W-1:0]  col_next,
    output logic [tcce_pkg::ROW_W-1:0]  row_next,
    output tcce_pkg::result_t           result
);
    import tcce_pkg::*;

    logic [COL_W:0]      col_inc;
    logic                last_row;
    logic                wv;
    logic                scroll;
    logic [COL_W-1:0]    wcol;
    logic [ROW_W-1:0]    wrow;
    logic [CHAR_W-1:0]   glyph;

    assign col_inc  = {1'b0, cursor_col} + (COL_W+1)'(1);
    assign last_row = (cursor_row == ROW_W'(ROWS - 1));

    always_comb
    begin
        col_next = cursor_col;
        row_next = cursor_row;
        wv       = 1'b0;
        scroll   = 1'b0;
        wcol     = cursor_col;
        wrow     = cursor_row;
        glyph    = char_code;
        case (char_code)
            CODE_NUL:
            begin
            end
            CODE_BACKSPACE:
            begin
                if (cursor_col != '0)
                begin
                    col_next = cursor_col - COL_W'(1);
                end
                else if (cursor_row != '0)
                begin
                    row_next = cursor_row - ROW_W'(1);
                    col_next = COL_W'(COLUMNS - 1);
                end
                wv    = 1'b1;
                wcol  = col_next;
                wrow  = row_next;
                glyph = CODE_SPACE;
            end
            CODE_NEWLINE:
            begin
                col_next = '0;
                if (last_row)
                begin
                    scroll = 1'b1;
                end
                else
                begin
                    row_next = cursor_row + ROW_W'(1);
                end
            end
            default:
            begin
                wv = 1'b1;
                if (col_inc >= (COL_W+1)'(COLUMNS))
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        scroll = 1'b1;
                    end
                    else
                    begin
                        row_next = cursor_row + ROW_W'(1);
                    end
                end
                else
                begin
                    col_next = col_inc[COL_W-1:0];
                end
            end
        endcase
    end

    always_comb
    begin
        result.write_valid    = wv;
        result.write_row      = wv ? OUT_ROW_W'(wrow) : '0;
        result.write_col      = wv ? OUT_COL_W'(wcol) : '0;
        result.write_glyph    = wv ? glyph : '0;
        result.write_attr     = wv ? text_color : '0;
        result.scroll_request = scroll;
        result.cursor_row_out = OUT_ROW_W'(row_next);
        result.cursor_col_out = OUT_COL_W'(col_next);
    end

endmodule

[hdl/text_console_cursor_engine_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text screen cursor engine: one character in, one cell write result out.
// ----------------------------------------------------------------------------
// Registers: an input register, then a result register, lie between an input
//   transaction and result valid.
// Throughput: one character per cycle while the result is taken; the cursor
//   update is a single pass of compares and increments between the two registers.
// Reset: cursor at row 0, column 0; text color 7; both stages empty.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [tcce_pkg::ATTR_W-1:0] cfg_write_data,
    tcce_char_if.sink                   char_chan,
    tcce_result_if.source               result_chan
);
    import tcce_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ATTR_W-1:0] color_reg;
    logic              advance;

    assign advance         = in_valid_reg && (!out_valid_reg || result_chan.ready);
    assign char_chan.ready = !in_valid_reg || advance;

    tcce_cursor_step u_step (
        .cursor_col (col_reg),
        .cursor_row (row_reg),
        .char_code  (char_reg),
        .text_color (color_reg),
        .col_next   (col_next),
        .row_next   (row_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            color_reg     <= TEXT_COLOR_RESET;
        end
        else
        begin
            if (char_chan.ready)
            begin
                in_valid_reg <= char_chan.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                col_reg       <= col_next;
                row_reg       <= row_next;
            end
            else if (result_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write_en)
            begin
                color_reg <= cfg_write_data;
            end
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            char_reg <= char_chan.char_code;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_chan.valid          = out_valid_reg;
    assign result_chan.write_valid    = result_reg.write_valid;
    assign result_chan.write_row      = result_reg.write_row;
    assign result_chan.write_col      = result_reg.write_col;
    assign result_chan.write_glyph    = result_reg.write_glyph;
    assign result_chan.write_attr     = result_reg.write_attr;
    assign result_chan.scroll_request = result_reg.scroll_request;
    assign result_chan.cursor_row_out = result_reg.cursor_row_out;
    assign result_chan.cursor_col_out = result_reg.cursor_col_out;

endmodule
